// ===== sv/phr_pkg.sv =====
// ----------------------------------------------------------------------------
// phr_pkg
// Shared constants and types for the PPG heart-rate estimator.
// ----------------------------------------------------------------------------
`default_nettype none
package phr_pkg;

  localparam int FracBitsDefault = 16;
  localparam int SampleW = 18;
  localparam int TimeW = 32;
  localparam int RateW = 12;
  localparam int CountW = 16;
  localparam int AcW = 19;
  localparam int CfgIdxW = 3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegAcMin = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDcMin = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDcMax = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBpmMin = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBpmMax = 3'd4;
  localparam logic [CfgIdxW-1:0] RegRefract = 3'd5;

  // filter gains numerators and denominators
  localparam int DcNum = 5;
  localparam int DcDen = 1000;
  localparam int LpNum = 15;
  localparam int LpDen = 100;
  localparam int AmpNum = 5;
  localparam int AmpDen = 100;
  localparam int ThrNum = 60;
  localparam int ThrDen = 100;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DC_MUL,
    ST_LP_MUL,
    ST_AMP_MUL,
    ST_THR_MUL,
    ST_PEAK,
    ST_DIV_CHK,
    ST_DIV_RUN,
    ST_AVG_MUL,
    ST_AVG_DIV,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== sv/phr_qmul.sv =====
// ----------------------------------------------------------------------------
// phr_qmul
// Bit-serial signed by unsigned-gain multiply, round half away from zero.
// ----------------------------------------------------------------------------
`default_nettype none
module phr_qmul #(
  parameter int W = 40,
  parameter int GW = 17,
  parameter int FB = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic signed [W-1:0] v,
  input  wire logic [GW-1:0]     gain,
  output logic                   done,
  output logic signed [W-1:0]    prod
);
  localparam int AW = W + GW;
  localparam int CW = $clog2(GW + 1);

  logic [W-1:0] mag;
  logic [GW-1:0] gsh;
  logic [AW-1:0] acc;
  logic neg;
  logic busy;
  logic [CW-1:0] cnt;
  logic [AW-1:0] rnd;

  // shift-add one gain bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && cnt == CW'(GW - 1);
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(GW - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= v[W-1];
      mag <= v[W-1] ? W'(-v) : W'(v);
      gsh <= gain;
      acc <= '0;
    end else if (busy) begin
      if (gsh[0]) acc <= acc + (AW'(mag) << cnt);
      gsh <= gsh >> 1;
    end
  end

  assign rnd = (acc + (AW'(1) << (FB - 1))) >> FB;
  assign prod = neg ? -$signed(W'(rnd)) : $signed(W'(rnd));
endmodule
`default_nettype wire

// ===== sv/phr_div.sv =====
// ----------------------------------------------------------------------------
// phr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module phr_div #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              done,
  output logic [W-1:0]      quo
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] rem;
  logic [W-1:0] nsh;
  logic [W-1:0] d;
  logic [CW-1:0] cnt;
  logic busy;
  logic [W:0] trial;

  assign trial = {rem, nsh[W-1]} - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && cnt == CW'(W - 1);
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // shift one numerator bit into the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      nsh <= num;
      d <= den;
      quo <= '0;
    end else if (busy) begin
      nsh <= nsh << 1;
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], nsh[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/ppg_heart_rate_estimator_top.sv =====
// ----------------------------------------------------------------------------
// ppg_heart_rate_estimator_top
// PPG heart-rate estimator: DC/AC filters, peak detection, beat rate.
// ----------------------------------------------------------------------------
// channel  dir  beat
// s_axis   in   tdata = ir_sample, timestamp_ms; tuser = restart
// m_axis   out  tdata = ac_value .. peak_total, one result per sample
// cfg      in   cfg_index selects register, cfg_data is the value
//
// Each multiply runs through the shared serial multiplier. With contact a
// sample takes four multiplies (DC, low-pass, amplitude, threshold) from
// accept to result, without contact three. A peak that gives a rate adds a
// serial divide, and a second one when the average needs its divide by 100.
// A restart sample goes from accept straight to the done state. One sample in
// flight; a finished result waits until the output register is free.
// rst is synchronous, restores register defaults and clears the filter, peak and rate state.
// ----------------------------------------------------------------------------
`default_nettype none
module ppg_heart_rate_estimator_top #(
  parameter int FRAC_BITS = phr_pkg::FracBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [17:0] ir_sample, [49:18] timestamp_ms, [55:50] zero
  input  wire logic [55:0] s_axis_tdata,
  // [0] restart
  input  wire logic        s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [18:0] ac_value, [19] skin_contact, [20] signal_good, [21] peak_found,
  // [22] rate_valid, [34:23] rate_instant, [46:35] rate_average,
  // [62:47] peak_total, [63] zero
  output logic [63:0]      m_axis_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [phr_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import phr_pkg::*;

  localparam int W = SampleW + FRAC_BITS + 6;
  localparam int GW = FRAC_BITS + 1;
  localparam logic [GW-1:0] GDc = GW'(((DcNum << FRAC_BITS) + DcDen / 2) / DcDen);
  localparam logic [GW-1:0] GLp = GW'(((LpNum << FRAC_BITS) + LpDen / 2) / LpDen);
  localparam logic [GW-1:0] GAmp = GW'(((AmpNum << FRAC_BITS) + AmpDen / 2) / AmpDen);
  localparam logic [GW-1:0] GThr = GW'(((ThrNum << FRAC_BITS) + ThrDen / 2) / ThrDen);

  // configuration registers
  logic [SampleW-1:0] ac_min, dc_min, dc_max;
  logic [7:0] bpm_min, bpm_max;
  logic [15:0] holdoff_ms;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ac_min <= 18'd30;
      dc_min <= 18'd20000;
      dc_max <= 18'd250000;
      bpm_min <= 8'd40;
      bpm_max <= 8'd200;
      holdoff_ms <= 16'd250;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegAcMin: ac_min <= cfg_data[SampleW-1:0];
        RegDcMin: dc_min <= cfg_data[SampleW-1:0];
        RegDcMax: dc_max <= cfg_data[SampleW-1:0];
        RegBpmMin: bpm_min <= cfg_data[7:0];
        RegBpmMax: bpm_max <= cfg_data[7:0];
        RegRefract: holdoff_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // estimator state
  logic signed [W-1:0] dc_level, ac_smoothed, amplitude_avg, hist_prev, hist_prev2;
  logic signed [W-1:0] x, thr;
  logic [TimeW-1:0] now, last_peak_time, dt;
  logic have_peak, rate_ok, peak, restart;
  logic [CountW-1:0] peak_counter;
  logic [RateW-1:0] rate_last, rate_avg_reg, rate_new;

  state_t state, state_next;

  // shared multiplier
  logic mul_start, mul_done;
  logic signed [W-1:0] mul_v, mul_p;
  logic [GW-1:0] mul_g;

  phr_qmul #(.W(W), .GW(GW), .FB(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .v(mul_v), .gain(mul_g),
    .done(mul_done), .prod(mul_p)
  );

  // shared divider
  logic div_start, div_done;
  logic [TimeW-1:0] div_num, div_den, div_q;

  phr_div #(.W(TimeW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_q)
  );

  logic signed [W-1:0] lo_q, hi_q, acmin_q, thr_eff, ac;
  logic contact, signal_good, is_peak, range_ok;
  logic [TimeW+8:0] min_prod, max_prod;

  assign lo_q = W'({dc_min, FRAC_BITS'(0)});
  assign hi_q = W'({dc_max, FRAC_BITS'(0)});
  assign acmin_q = W'({ac_min, FRAC_BITS'(0)});
  assign contact = dc_level >= lo_q && dc_level <= hi_q;
  assign signal_good = contact && amplitude_avg >= acmin_q;
  assign ac = x - dc_level;
  assign thr_eff = thr < acmin_q ? acmin_q : thr;
  assign is_peak = hist_prev > hist_prev2 && hist_prev > ac_smoothed && hist_prev > thr_eff;
  assign dt = now - last_peak_time;
  assign min_prod = (TimeW+9)'(bpm_min) * (TimeW+9)'(dt);
  assign max_prod = (TimeW+9)'(bpm_max) * (TimeW+9)'(dt);
  assign range_ok = dt != '0 && min_prod <= (TimeW+9)'(60000) &&
                    max_prod >= (TimeW+9)'(60000);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid && s_axis_tready)
        state_next = s_axis_tuser ? ST_DONE : ST_DC_MUL;
      ST_DC_MUL: if (mul_done) state_next = ST_LP_MUL;
      ST_LP_MUL: if (mul_done) state_next = ST_AMP_MUL;
      ST_AMP_MUL: if (mul_done) state_next = contact ? ST_THR_MUL : ST_DONE;
      ST_THR_MUL: if (mul_done) state_next = ST_PEAK;
      ST_PEAK: begin
        if (is_peak && (!have_peak || dt >= TimeW'(holdoff_ms)))
          state_next = (have_peak && range_ok) ? ST_DIV_RUN : ST_DONE;
        else
          state_next = ST_DONE;
      end
      ST_DIV_RUN: if (div_done) state_next = ST_AVG_MUL;
      ST_AVG_MUL: state_next = (rate_avg_reg <= RateW'(1)) ? ST_DONE : ST_AVG_DIV;
      ST_AVG_DIV: if (div_done) state_next = ST_DONE;
      ST_DONE: if (!m_axis_tvalid || m_axis_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mul_start = 1'b0;
    mul_v = '0;
    mul_g = '0;
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    case (state)
      ST_IDLE: begin
        mul_start = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
        mul_v = W'({s_axis_tdata[SampleW-1:0], FRAC_BITS'(0)}) - dc_level;
        mul_g = GDc;
      end
      ST_DC_MUL: begin
        mul_start = mul_done;
        mul_v = ac - mul_p - ac_smoothed;
        mul_g = GLp;
      end
      ST_LP_MUL: begin
        mul_start = mul_done;
        mul_v = (ac_smoothed + mul_p < 0 ? -(ac_smoothed + mul_p) : ac_smoothed + mul_p)
                - amplitude_avg;
        mul_g = GAmp;
      end
      ST_AMP_MUL: begin
        mul_start = mul_done && contact;
        mul_v = amplitude_avg + mul_p;
        mul_g = GThr;
      end
      ST_PEAK: begin
        div_start = is_peak && have_peak && dt >= TimeW'(holdoff_ms) && range_ok;
        div_num = TimeW'(960000) + (dt >> 1);
        div_den = dt;
      end
      ST_DIV_RUN: ;
      ST_AVG_MUL: begin
        div_start = rate_avg_reg > RateW'(1);
        div_num = TimeW'(85) * TimeW'(rate_avg_reg) + TimeW'(15) * TimeW'(rate_last) +
                  TimeW'(50);
        div_den = TimeW'(100);
      end
      default: ;
    endcase
  end

  assign s_axis_tready = state == ST_IDLE;
  assign rate_new = RateW'(div_q);

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
      dc_level <= '0;
      ac_smoothed <= '0;
      amplitude_avg <= '0;
      hist_prev <= '0;
      hist_prev2 <= '0;
      last_peak_time <= '0;
      have_peak <= 1'b0;
      peak_counter <= '0;
      rate_last <= '0;
      rate_avg_reg <= '0;
      rate_ok <= 1'b0;
      peak <= 1'b0;
    end else begin
      state <= state_next;
      // result register: load when free, clear when taken
      if (state == ST_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          x <= W'({s_axis_tdata[SampleW-1:0], FRAC_BITS'(0)});
          now <= s_axis_tdata[SampleW +: TimeW];
          restart <= s_axis_tuser;
          peak <= 1'b0;
          if (s_axis_tuser) begin
            dc_level <= W'({s_axis_tdata[SampleW-1:0], FRAC_BITS'(0)});
            ac_smoothed <= '0;
            amplitude_avg <= '0;
            hist_prev <= '0;
            hist_prev2 <= '0;
            last_peak_time <= '0;
            have_peak <= 1'b0;
            peak_counter <= '0;
            rate_last <= '0;
            rate_avg_reg <= '0;
            rate_ok <= 1'b0;
          end
        end
        ST_DC_MUL: if (mul_done) dc_level <= dc_level + mul_p;
        ST_LP_MUL: if (mul_done) ac_smoothed <= ac_smoothed + mul_p;
        ST_AMP_MUL: if (mul_done) begin
          amplitude_avg <= amplitude_avg + mul_p;
          if (!contact) rate_ok <= 1'b0;
        end
        ST_THR_MUL: if (mul_done) thr <= mul_p;
        ST_PEAK: begin
          if (is_peak && (!have_peak || dt >= TimeW'(holdoff_ms))) begin
            if (have_peak && !range_ok) rate_ok <= 1'b0;
            last_peak_time <= now;
            have_peak <= 1'b1;
            if (peak_counter != '1) peak_counter <= peak_counter + 1'b1;
            peak <= 1'b1;
          end
          hist_prev2 <= hist_prev;
          hist_prev <= ac_smoothed;
        end
        ST_DIV_RUN: if (div_done) begin
          rate_last <= rate_new;
          rate_ok <= 1'b1;
        end
        ST_AVG_MUL: if (rate_avg_reg <= RateW'(1)) rate_avg_reg <= rate_last;
        ST_AVG_DIV: if (div_done) rate_avg_reg <= rate_new;
        ST_DONE: if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= {1'b0, peak_counter, rate_avg_reg, rate_last, rate_ok,
                           peak && !restart, signal_good, contact,
                           restart ? AcW'(0) : AcW'(ac_smoothed >>> FRAC_BITS)};
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PPG heart-rate estimator. Samples go in on the
// sample stream, one result per sample comes out and is compared field by
// field against a fixed-point beat tracker kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import phr_pkg::*;

  localparam int FB = FracBitsDefault;
  localparam longint QMASK = (64'd1 << FB) - 1;
  localparam longint QHALF = 64'd1 << (FB - 1);
  localparam longint GAIN_DC = ((64'd5 << FB) + 500) / 1000;
  localparam longint GAIN_LP = ((64'd15 << FB) + 50) / 100;
  localparam longint GAIN_AMP = ((64'd5 << FB) + 50) / 100;
  localparam longint GAIN_THR = ((64'd60 << FB) + 50) / 100;
  localparam longint CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic        restart;
    logic [31:0] stamp;
    logic [17:0] ir;
  } sample_t;

  typedef struct packed {
    logic [15:0] peaks;
    logic [11:0] avg;
    logic [11:0] inst;
    logic        rvalid;
    logic        peak;
    logic        sig;
    logic        contact;
    logic [18:0] ac;
  } beat_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  ppg_heart_rate_estimator_top dut (.*);

  always #2 clk = ~clk;

  // register shadow
  longint r_acmin, r_dcmin, r_dcmax, r_bpmmin, r_bpmmax, r_refr;
  // tracker state
  longint dc, acs, amp, h1, h2;
  logic [31:0] last_t;
  bit have_pk, rok;
  int unsigned pk_cnt, r_last, r_avg;

  sample_t pending_samples[$];
  beat_result_t expected_beats[$];
  int errors = 0;
  longint cycles = 0;
  bit long_hold = 0;
  bit idle_free = 0;
  bit in_fire = 0;
  int hold_cnt = 0;

  function automatic longint qscale(longint v, longint c);
    longint mag, r;
    mag = v < 0 ? -v : v;
    r = (mag >>> FB) * c + (((mag & QMASK) * c + QHALF) >>> FB);
    return v < 0 ? -r : r;
  endfunction

  function automatic longint floor_q(longint v);
    if (v >= 0) return v >>> FB;
    return -((-v + QMASK) >>> FB);
  endfunction

  task automatic clear_tracker();
    dc = 0; acs = 0; amp = 0; h1 = 0; h2 = 0; last_t = 0;
    have_pk = 0; pk_cnt = 0; r_last = 0; r_avg = 0; rok = 0;
  endtask

  // advance the beat tracker by one sample and queue its result
  task automatic track_sample(sample_t s);
    longint x, ac, mag, thr, d, lo, hi, amin;
    logic [31:0] dt;
    int unsigned r;
    bit contact, sig, pk;
    beat_result_t e;
    x = longint'(s.ir) << FB;
    lo = r_dcmin << FB; hi = r_dcmax << FB; amin = r_acmin << FB;
    pk = 0;
    if (s.restart) begin
      clear_tracker();
      dc = x;
    end else begin
      dc += qscale(x - dc, GAIN_DC);
      ac = x - dc;
      acs += qscale(ac - acs, GAIN_LP);
      mag = acs < 0 ? -acs : acs;
      amp += qscale(mag - amp, GAIN_AMP);
    end
    contact = dc >= lo && dc <= hi;
    sig = contact && amp >= amin;
    if (!s.restart) begin
      if (contact) begin
        thr = qscale(amp, GAIN_THR);
        if (thr < amin) thr = amin;
        if (h1 > h2 && h1 > acs && h1 > thr) begin
          dt = s.stamp - last_t;
          if (!have_pk || longint'(dt) >= r_refr) begin
            if (have_pk) begin
              d = longint'(dt);
              if (d != 0 && r_bpmmin * d <= 60000 && r_bpmmax * d >= 60000) begin
                r = int'((960000 + d / 2) / d);
                r_last = r;
                if (r_avg <= 1) r_avg = r;
                else r_avg = (85 * r_avg + 15 * r + 50) / 100;
                rok = 1;
              end else begin
                rok = 0;
              end
            end
            last_t = s.stamp;
            have_pk = 1;
            if (pk_cnt < 16'hFFFF) pk_cnt++;
            pk = 1;
          end
        end
        h2 = h1;
        h1 = acs;
      end else begin
        rok = 0;
      end
    end
    e.ac = s.restart ? '0 : 19'(floor_q(acs));
    e.contact = contact; e.sig = sig; e.peak = pk; e.rvalid = rok;
    e.inst = 12'(r_last); e.avg = 12'(r_avg); e.peaks = 16'(pk_cnt);
    expected_beats.push_back(e);
  endtask

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("error: %s got %0h want %0h", what, got, want);
  endtask

  // input acceptance seen at the rising edge
  always @(posedge clk) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
  end

  // sample driver
  always @(negedge clk) begin
    cycles <= cycles + 1;
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (pending_samples.size() > 0 && (idle_free || $urandom_range(99) >= 18)) begin
        s_axis_tvalid <= 1'b1;
        {s_axis_tuser, s_axis_tdata[49:0]} <= pending_samples[0];
        track_sample(pending_samples.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (long_hold && hold_cnt < 400) begin
      hold_cnt <= hold_cnt + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !rst && (idle_free || $urandom_range(99) >= 18);
    end
  end

  // result checker
  always @(posedge clk) begin
    beat_result_t g, e;
    if (m_axis_tvalid && m_axis_tready) begin
      g = m_axis_tdata[62:0];
      if (expected_beats.size() == 0) begin
        report("unexpected beat", 0, 0);
      end else begin
        e = expected_beats.pop_front();
        if (g.ac != e.ac) report("ac_value", g.ac, e.ac);
        if (g.contact != e.contact) report("skin_contact", g.contact, e.contact);
        if (g.sig != e.sig) report("signal_good", g.sig, e.sig);
        if (g.peak != e.peak) report("peak_found", g.peak, e.peak);
        if (g.rvalid != e.rvalid) report("rate_valid", g.rvalid, e.rvalid);
        if (g.inst != e.inst) report("rate_instant", g.inst, e.inst);
        if (g.avg != e.avg) report("rate_average", g.avg, e.avg);
        if (g.peaks != e.peaks) report("peak_total", g.peaks, e.peaks);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("ppg_heart_rate_estimator_top: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, longint v);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= 32'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      RegAcMin: r_acmin = v;
      RegDcMin: r_dcmin = v;
      RegDcMax: r_dcmax = v;
      RegBpmMin: r_bpmmin = v;
      RegBpmMax: r_bpmmax = v;
      default: r_refr = v;
    endcase
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_beats.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic add(logic [17:0] ir, logic [31:0] t, bit rs);
    sample_t s;
    s.ir = ir; s.stamp = t; s.restart = rs;
    pending_samples.push_back(s);
  endtask

  // pulse-like waveform: period and sampling step tstep in ms, noisy content
  task automatic add_pulses(int n, int base, int swing, int period, int tstep,
                            inout logic [31:0] t);
    int v;
    for (int i = 0; i < n; i++) begin
      v = base + (((t % period) < period / 4) ? swing : 0)
          + $urandom_range(swing / 8 + 1);
      if (v > 262143) v = 262143;
      add(18'(v), t, 0);
      t += tstep;
    end
  endtask

  initial begin
    logic [31:0] t;
    int base;
    r_acmin = 30; r_dcmin = 20000; r_dcmax = 250000;
    r_bpmmin = 40; r_bpmmax = 200; r_refr = 250;
    clear_tracker();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, restart, wrap, zero interval, out of range
    add(18'h3FFFF, 32'hFFFF_FFFF, 0);
    add(18'd0, 32'd0, 0);
    add(18'd100000, 32'hFFFF_FF00, 1);
    add(18'h3FFFF, 32'hFFFF_FF20, 0);
    add(18'd0, 32'hFFFF_FF40, 0);
    add(18'h3FFFF, 32'hFFFF_FFF0, 0);
    add(18'd100000, 32'h0000_0100, 0);
    add(18'd100000, 32'h0000_0100, 0);
    add(18'd5, 32'd7, 1);
    add(18'd5, 32'd27, 0);
    add(18'h3FFFF, 32'd47, 1);
    add(18'h3FFFF, 32'd67, 0);
    drain();

    // zero refractory, same timestamp peaks
    write_reg(RegRefract, 0);
    write_reg(RegAcMin, 0);
    add(18'd100000, 32'd0, 1);
    for (int i = 0; i < 12; i++) add(18'(100000 + ((i % 3 == 1) ? 20000 : 0)), 32'd500, 0);
    drain();

    // several settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(RegAcMin, 30); write_reg(RegDcMin, 20000);
          write_reg(RegDcMax, 250000); write_reg(RegBpmMin, 40);
          write_reg(RegBpmMax, 200); write_reg(RegRefract, 250);
        end
        1: begin
          write_reg(RegAcMin, 262143); write_reg(RegDcMin, 262143);
          write_reg(RegDcMax, 0); write_reg(RegBpmMin, 255);
          write_reg(RegBpmMax, 1); write_reg(RegRefract, 65535);
        end
        2: begin
          write_reg(RegAcMin, 0); write_reg(RegDcMin, 0);
          write_reg(RegDcMax, 262143); write_reg(RegBpmMin, 1);
          write_reg(RegBpmMax, 255); write_reg(RegRefract, 0);
        end
        3: begin
          write_reg(RegAcMin, $urandom_range(200)); write_reg(RegDcMin, 30000);
          write_reg(RegDcMax, 200000); write_reg(RegBpmMin, 50);
          write_reg(RegBpmMax, 150); write_reg(RegRefract, 300);
        end
        4: begin
          idle_free = 1;
          write_reg(RegAcMin, 10); write_reg(RegDcMin, 1000);
          write_reg(RegDcMax, 260000); write_reg(RegBpmMin, 30);
          write_reg(RegBpmMax, 220); write_reg(RegRefract, 200);
        end
        default: begin
          idle_free = 0;
          write_reg(RegAcMin, 30); write_reg(RegDcMin, 20000);
          write_reg(RegDcMax, 250000); write_reg(RegBpmMin, 40);
          write_reg(RegBpmMax, 200); write_reg(RegRefract, 250);
        end
      endcase
      t = $urandom;
      for (int blk = 0; blk < 5; blk++) begin
        base = $urandom_range(250000, 5000);
        add(18'(base), t, 1);
        t += 20;
        if ($urandom_range(9) == 0) begin
          // noise
          for (int i = 0; i < 20; i++) begin
            add(18'($urandom), t, $urandom_range(30) == 0);
            t += $urandom_range(40);
          end
        end else begin
          add_pulses(57, base, $urandom_range(3000, 20), $urandom_range(1500, 260),
                     $urandom_range(25, 10), t);
        end
      end
      if (ph == 3) long_hold = 1;
      drain();
    end

    if (errors == 0) begin
      $display("ppg_heart_rate_estimator_top: match");
    end else begin
      $display("ppg_heart_rate_estimator_top: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== ppg_heart_rate_estimator_top.f =====
sv/phr_pkg.sv
sv/phr_qmul.sv
sv/phr_div.sv
sv/ppg_heart_rate_estimator_top.sv
tb/tb_top.sv
